// File: rtl/rmbe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the raster mask boundary edge extractor.
// No dependencies; every other file in rtl imports this package.
package rmbe_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_AW  = 4;
    localparam int CFG_DW  = 32;
    localparam int DIM_W   = 13;
    localparam int CLASS_W = 16;
    localparam int POS_W   = 12;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MATCH_CLASS = 2'd2;

    typedef enum logic [1:0] {
        SIDE_TOP    = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_BOTTOM = 2'd2,
        SIDE_LEFT   = 2'd3
    } t_side;

    typedef struct packed {
        logic [DIM_W-1:0]   grid_width;
        logic [DIM_W-1:0]   grid_height;
        logic [CLASS_W-1:0] match_class;
    } t_cfg;

    // Neighborhood of one cell after the line store read.
    typedef struct packed {
        logic             in_mask;
        logic             row_nz;
        logic             left_mask;
        logic             last_col;
        logic             last_row;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_cell_info;

endpackage

// File: rtl/rmbe_cfg.sv
`timescale 1ns / 1ps
// Configuration register file behind an APB-style port.
// Depends on rmbe_pkg.
module rmbe_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rmbe_pkg::CFG_AW-1:0] paddr,
    input  logic [rmbe_pkg::CFG_DW-1:0] pwdata,
    output logic [rmbe_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output rmbe_pkg::t_cfg             o_cfg
);
    import rmbe_pkg::*;

    logic [DIM_W-1:0]   r_grid_width;
    logic [DIM_W-1:0]   r_grid_height;
    logic [CLASS_W-1:0] r_match_class;
    logic [1:0]         w_index;
    logic               w_wr;

    assign pready  = 1'b1;
    assign w_index = paddr[3:2];
    assign w_wr    = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= DIM_W'(1);
            r_grid_height <= DIM_W'(1);
            r_match_class <= CLASS_W'(1);
        end else if (w_wr) begin
            case (w_index)
                REG_GRID_WIDTH:  r_grid_width  <= pwdata[DIM_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= pwdata[DIM_W-1:0];
                REG_MATCH_CLASS: r_match_class <= pwdata[CLASS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_GRID_WIDTH:  prdata = {{(CFG_DW-DIM_W){1'b0}}, r_grid_width};
            REG_GRID_HEIGHT: prdata = {{(CFG_DW-DIM_W){1'b0}}, r_grid_height};
            REG_MATCH_CLASS: prdata = {{(CFG_DW-CLASS_W){1'b0}}, r_match_class};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.grid_width  = r_grid_width;
    assign o_cfg.grid_height = r_grid_height;
    assign o_cfg.match_class = r_match_class;

endmodule

// File: rtl/rmbe_line.sv
`timescale 1ns / 1ps
// Raster position counters, left mask bit and the one-bit line store of the
// previous row's mask. Depends on rmbe_pkg.
module rmbe_line #(
    parameter int MAX_WIDTH  = rmbe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rmbe_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rmbe_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    input  logic [rmbe_pkg::CLASS_W-1:0]  i_class,
    input  logic                          i_finite,
    output logic                          o_ready,
    output logic                          o_valid,
    output rmbe_pkg::t_cell_info          o_info,
    output logic                          o_above,
    input  logic                          i_ready
);
    import rmbe_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int DWW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam int DWH = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;

    logic           mem [MAX_WIDTH];
    logic           r_rd;
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic           r_left;
    logic           r_valid;
    t_cell_info     r_info;

    logic [DWW-1:0]   w_wv;
    logic [DWH-1:0]   w_hv;
    logic [CW-1:0]    w_wlast;
    logic [RW-1:0]    w_hlast;
    logic             w_mask;
    logic             w_accept;
    logic             w_last_col;
    logic             w_last_row;
    logic [CW+11:0]   w_col_ext;
    logic [RW+11:0]   w_row_ext;
    logic [CW-1:0]    n_col;
    logic [RW-1:0]    n_row;

    // Clamp the grid size into 1..MAX and keep the last valid index.
    always_comb begin
        w_wv = DWW'(i_cfg.grid_width);
        w_hv = DWH'(i_cfg.grid_height);
        if (w_wv == '0) begin
            w_wlast = '0;
        end else if (w_wv > DWW'(MAX_WIDTH)) begin
            w_wlast = CW'(MAX_WIDTH - 1);
        end else begin
            w_wlast = CW'(w_wv - DWW'(1));
        end
        if (w_hv == '0) begin
            w_hlast = '0;
        end else if (w_hv > DWH'(MAX_HEIGHT)) begin
            w_hlast = RW'(MAX_HEIGHT - 1);
        end else begin
            w_hlast = RW'(w_hv - DWH'(1));
        end
    end

    assign w_mask     = (i_class == i_cfg.match_class) && i_finite;
    assign o_ready    = !r_valid || i_ready;
    assign w_accept   = i_valid && o_ready;
    assign w_last_col = r_col >= w_wlast;
    assign w_last_row = r_row >= w_hlast;
    assign w_col_ext  = {12'd0, r_col};
    assign w_row_ext  = {12'd0, r_row};

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_last_col) begin
            n_col = '0;
            n_row = w_last_row ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    // The store read returns the previous row's bit at this column; the write
    // of the same entry in the same edge does not disturb it.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            mem[r_col] <= w_mask;
            r_rd       <= mem[r_col];
            r_info.in_mask   <= w_mask;
            r_info.row_nz    <= (r_row != '0);
            r_info.left_mask <= (r_col != '0) && r_left;
            r_info.last_col  <= w_last_col;
            r_info.last_row  <= w_last_row;
            r_info.row       <= w_row_ext[11:0];
            r_info.col       <= w_col_ext[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_left  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_left <= w_mask;
            end
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_info  = r_info;
    assign o_above = r_info.row_nz && r_rd;

`ifndef SYNTHESIS
    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_info)))
        else $error("cell stage changed while stalled");
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last_col) |=> (r_col == '0))
        else $error("column did not wrap after last column");
    a_left_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_col == '0)) |=> !r_info.left_mask)
        else $error("left neighbor seen in first column");
`endif

endmodule

// File: rtl/rmbe_emit.sv
`timescale 1ns / 1ps
// Expands one cell's neighborhood into edge transactions, at most one per side, and
// holds them in the output register. Depends on rmbe_pkg.
module rmbe_emit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  rmbe_pkg::t_cell_info            i_info,
    input  logic                            i_above,
    output logic                            o_ready,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [rmbe_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tlast
);
    import rmbe_pkg::*;

    // Slot order: mask cell -> top, right, bottom, left.
    // Non-mask cell -> bottom of the cell above, right of the cell to the left.
    logic [3:0]       r_pend;
    logic             r_nm;
    logic [POS_W-1:0] r_row0, r_col0, r_row1, r_col1;
    logic             r_valid;
    logic             r_last;
    logic [POS_W-1:0] r_orow, r_ocol;
    t_side            r_oside;

    logic             w_out_free;
    logic             w_emit;
    logic             w_load;
    logic [1:0]       w_idx;
    logic [3:0]       w_rest;
    t_side            w_side;
    logic [3:0]       n_pend;

    always_comb begin
        if (r_pend[0]) begin
            w_idx = 2'd0;
        end else if (r_pend[1]) begin
            w_idx = 2'd1;
        end else if (r_pend[2]) begin
            w_idx = 2'd2;
        end else begin
            w_idx = 2'd3;
        end
        w_rest = r_pend & ~(4'b0001 << w_idx);
        if (r_nm) begin
            w_side = (w_idx == 2'd0) ? SIDE_BOTTOM : SIDE_RIGHT;
        end else begin
            w_side = t_side'(w_idx);
        end
    end

    assign w_out_free = !r_valid || i_m_tready;
    assign w_emit     = (r_pend != 4'b0000) && w_out_free;
    assign o_ready    = (r_pend == 4'b0000) || (w_emit && (w_rest == 4'b0000));
    assign w_load     = i_valid && o_ready;

    always_comb begin
        if (i_info.in_mask) begin
            n_pend = {!i_info.left_mask, i_info.last_row, i_info.last_col, !i_above};
        end else begin
            n_pend = {2'b00, i_info.left_mask, i_above};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_nm   <= !i_info.in_mask;
            r_row1 <= i_info.row;
            r_col0 <= i_info.col;
            r_row0 <= i_info.in_mask ? i_info.row : i_info.row - POS_W'(1);
            r_col1 <= i_info.in_mask ? i_info.col : i_info.col - POS_W'(1);
        end
        if (w_emit) begin
            r_orow  <= (w_idx == 2'd0) ? r_row0 : r_row1;
            r_ocol  <= (w_idx == 2'd0) ? r_col0 : r_col1;
            r_oside <= w_side;
            r_last  <= (w_rest == 4'b0000);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 4'b0000;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_pend <= n_pend;
            end else if (w_emit) begin
                r_pend <= w_rest;
            end
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = {6'd0, r_oside, r_ocol, r_orow};

`ifndef SYNTHESIS
    a_nm_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_nm && (r_pend[3:2] != 2'b00)))
        else $error("non-mask cell holds mask-only edges");
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_valid)
        else $error("emitted edge not presented");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_pend != 4'b0000)) |-> (w_emit && $onehot(r_pend)))
        else $error("new cell loaded over pending edges");
`endif

endmodule

// File: rtl/raster_mask_boundary_edges_top.sv
`timescale 1ns / 1ps
// Top level of the raster mask boundary edge extractor.
// Depends on rmbe_pkg, rmbe_cfg, rmbe_line and rmbe_emit.
//
//   Channel   Direction  Signals                                   Contents
//   s (cells) in         i_s_tvalid/o_s_tready/i_s_tdata/i_s_tuser  class, finite flag
//   m (edges) out        o_m_tvalid/i_m_tready/o_m_tdata/o_m_tlast  row, col, side, last
//   apb       in/out     psel/penable/pwrite/paddr/pwdata/prdata    grid size, target
//
// A cell is registered together with its line store read, then each of its edges
// passes in turn through the single output register (at most four per cell), and the
// edge emitter takes the next cell as the last edge of the current one goes out.
// Cells with no edge flow at one per cycle while no edges are pending. Reset clears
// counters, left bit and handshake state; the line store is not cleared. Backpressure
// on the edge side stalls the emitter, then the cell stage, then o_s_tready.
module raster_mask_boundary_edges_top #(
    parameter int MAX_WIDTH  = rmbe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rmbe_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [rmbe_pkg::S_TDATA_W-1:0]  i_s_tdata,  // [15:0] cell_class
    input  logic                            i_s_tuser,  // [0] cell_finite
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [11:0] edge_row, [23:12] edge_col, [25:24] edge_side, [31:26] zero
    output logic [rmbe_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tlast,  // last_of_run
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rmbe_pkg::CFG_AW-1:0]     paddr,
    input  logic [rmbe_pkg::CFG_DW-1:0]     pwdata,
    output logic [rmbe_pkg::CFG_DW-1:0]     prdata,
    output logic                            pready
);
    import rmbe_pkg::*;

    t_cfg       w_cfg;
    logic       w_cell_valid;
    logic       w_cell_ready;
    t_cell_info w_info;
    logic       w_above;

    rmbe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rmbe_line #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (i_s_tvalid),
        .i_class  (i_s_tdata[CLASS_W-1:0]),
        .i_finite (i_s_tuser),
        .o_ready  (o_s_tready),
        .o_valid  (w_cell_valid),
        .o_info   (w_info),
        .o_above  (w_above),
        .i_ready  (w_cell_ready)
    );

    rmbe_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_cell_valid),
        .i_info     (w_info),
        .i_above    (w_above),
        .o_ready    (w_cell_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// File: tb/rmbe_edge_checker.sv
`timescale 1ns / 1ps
// Edge checker for the raster mask boundary edge extractor: tracks the APB writes,
// predicts the boundary edges of every accepted cell and compares the edge stream.
// Depends on rmbe_pkg only.
module rmbe_edge_checker #(
    parameter int MAX_W = rmbe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_H = rmbe_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [rmbe_pkg::S_TDATA_W-1:0] i_s_tdata,  // [15:0] cell_class
    input  logic                           i_s_tuser,  // [0] cell_finite
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // [11:0] edge_row, [23:12] edge_col, [25:24] edge_side, [31:26] zero
    input  logic [rmbe_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic                           i_m_tlast,  // last_of_run
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [rmbe_pkg::CFG_AW-1:0]    paddr,
    input  logic [rmbe_pkg::CFG_DW-1:0]    pwdata,
    output int                             o_fail_count,
    output int                             o_edges_pending,
    output logic                           o_frame_start
);
    import rmbe_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        t_side            side;
        logic             last;
    } t_boundary_edge;

    t_boundary_edge     edges_due[$];
    t_boundary_edge     want;
    logic               above_mask [MAX_W];
    logic               left_in_mask;
    int unsigned        row_pos;
    int unsigned        col_pos;
    logic [DIM_W-1:0]   width_q;
    logic [DIM_W-1:0]   height_q;
    logic [CLASS_W-1:0] target_q;
    int                 fails = 0;

    function automatic int unsigned fit_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
        if (v == '0) return 1;
        if (32'(v) > lim) return lim;
        return 32'(v);
    endfunction

    function automatic t_boundary_edge mk_edge(input int unsigned r, input int unsigned c,
                                               input t_side s);
        t_boundary_edge e;
        e.row  = r[POS_W-1:0];
        e.col  = c[POS_W-1:0];
        e.side = s;
        e.last = 1'b0;
        return e;
    endfunction

    // Works out the edges one cell causes and advances the raster position.
    task automatic derive_cell_edges(input logic [CLASS_W-1:0] cls, input logic fin);
        t_boundary_edge run [4];
        int             n;
        int unsigned    w;
        int unsigned    h;
        int unsigned    r;
        int unsigned    c;
        logic           m;
        logic           up;
        logic           lft;
        n   = 0;
        w   = fit_dim(width_q, MAX_W);
        h   = fit_dim(height_q, MAX_H);
        r   = row_pos;
        c   = col_pos;
        m   = (cls == target_q) && fin;
        up  = (r > 0) && above_mask[c];
        lft = (c > 0) && left_in_mask;
        if (!m) begin
            // Pending bottom edge of the cell above, then the right edge of the cell to the left.
            if (up) begin
                run[n] = mk_edge(r - 1, c, SIDE_BOTTOM);
                n++;
            end
            if (lft) begin
                run[n] = mk_edge(r, c - 1, SIDE_RIGHT);
                n++;
            end
        end else begin
            if (!up) begin
                run[n] = mk_edge(r, c, SIDE_TOP);
                n++;
            end
            if (c + 1 >= w) begin
                run[n] = mk_edge(r, c, SIDE_RIGHT);
                n++;
            end
            if (r + 1 >= h) begin
                run[n] = mk_edge(r, c, SIDE_BOTTOM);
                n++;
            end
            if (!lft) begin
                run[n] = mk_edge(r, c, SIDE_LEFT);
                n++;
            end
        end
        for (int i = 0; i < n; i++) begin
            run[i].last = (i == n - 1);
            edges_due = {edges_due, run[i]};
        end
        above_mask[c] = m;
        left_in_mask  = m;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            edges_due.delete();
            row_pos      = 0;
            col_pos      = 0;
            left_in_mask = 1'b0;
            width_q      = DIM_W'(1);
            height_q     = DIM_W'(1);
            target_q     = CLASS_W'(1);
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (edges_due.size() == 0) begin
                    $error("edge transaction with none pending: tdata 0x%h tlast %0b",
                           i_m_tdata, i_m_tlast);
                    fails++;
                end else begin
                    want = edges_due.pop_front();
                    if (i_m_tdata[11:0] != want.row) begin
                        $error("edge_row mismatch: expected %0d, got %0d",
                               want.row, i_m_tdata[11:0]);
                        fails++;
                    end
                    if (i_m_tdata[23:12] != want.col) begin
                        $error("edge_col mismatch: expected %0d, got %0d",
                               want.col, i_m_tdata[23:12]);
                        fails++;
                    end
                    if (i_m_tdata[25:24] != want.side) begin
                        $error("edge_side mismatch: expected %0d, got %0d",
                               want.side, i_m_tdata[25:24]);
                        fails++;
                    end
                    if (i_m_tdata[31:26] != '0) begin
                        $error("tdata padding mismatch: expected 0, got %0d", i_m_tdata[31:26]);
                        fails++;
                    end
                    if (i_m_tlast != want.last) begin
                        $error("last_of_run mismatch: expected %0b, got %0b",
                               want.last, i_m_tlast);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                derive_cell_edges(i_s_tdata[CLASS_W-1:0], i_s_tuser);
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_GRID_WIDTH:  width_q  = pwdata[DIM_W-1:0];
                    REG_GRID_HEIGHT: height_q = pwdata[DIM_W-1:0];
                    REG_MATCH_CLASS: target_q = pwdata[CLASS_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count    <= fails;
        o_edges_pending <= edges_due.size();
        o_frame_start   <= (row_pos == 0) && (col_pos == 0);
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the edge extractor testbench: clock, reset, cell stimulus, APB setup and verdict.
// Depends on rmbe_pkg, raster_mask_boundary_edges_top and rmbe_edge_checker.
module testbench;
    import rmbe_pkg::*;

    localparam int MAX_W = DEF_MAX_WIDTH;

    localparam int READY_ALWAYS = 0;
    localparam int READY_COIN   = 1;
    localparam int READY_SPARSE = 2;
    localparam int READY_STEADY = 3;

    localparam logic [2:0] SET_W   = 3'b001;
    localparam logic [2:0] SET_H   = 3'b010;
    localparam logic [2:0] SET_TGT = 3'b100;
    localparam logic [2:0] SET_ALL = 3'b111;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 i_s_tuser  = 1'b0;
    logic                 i_m_tready = 1'b0;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [CFG_AW-1:0]    paddr      = '0;
    logic [CFG_DW-1:0]    pwdata     = '0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tlast;
    logic [CFG_DW-1:0]    prdata;
    logic                 pready;

    int          fail_count;
    int          edges_pending;
    logic        frame_start;
    int          burst_left   = 1;
    int          stall_mode   = READY_ALWAYS;
    int          mode_left    = 0;
    int unsigned cur_w        = 1;
    logic [15:0] cur_target   = 16'h0001;
    int          random_sent  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    raster_mask_boundary_edges_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    rmbe_edge_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_s_tuser       (i_s_tuser),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .i_m_tlast       (o_m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .o_fail_count    (fail_count),
        .o_edges_pending (edges_pending),
        .o_frame_start   (frame_start)
    );

    // The edge receiver switches between randomly chosen stall patterns.
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = int'($urandom_range(READY_ALWAYS, READY_STEADY));
            mode_left  = int'($urandom_range(16, 96));
        end
        mode_left--;
        case (stall_mode)
            READY_COIN:   i_m_tready = 1'($urandom_range(0, 1));
            READY_SPARSE: i_m_tready = ($urandom_range(0, 5) == 0);
            default:      i_m_tready = 1'b1;
        endcase
    end

    // Called at a falling edge; returns at a falling edge with tvalid possibly still high.
    task automatic send_cell(input logic [15:0] cls, input logic fin);
        i_s_tdata  = cls;
        i_s_tuser  = fin;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = int'($urandom_range(1, 40));
        end
    endtask

    task automatic send_random_cell(input int mask_pct);
        logic [15:0] cls;
        logic        fin;
        int          pick;
        if ($urandom_range(0, 99) < mask_pct) begin
            cls = cur_target;
            fin = 1'b1;
        end else begin
            pick = int'($urandom_range(0, 3));
            cls  = 16'($urandom);
            fin  = ($urandom_range(0, 3) != 0);
            if (pick == 0) begin
                cls = cur_target;
                fin = 1'b0;
            end else if (pick == 1) begin
                cls = cur_target ^ (16'h0001 << $urandom_range(0, 15));
            end
        end
        send_cell(cls, fin);
    endtask

    // Waits until every predicted edge has come out, then waits longer for cells
    // that cause no edge but may still sit in the pipeline.
    task automatic wait_edges_drained();
        i_s_tvalid = 1'b0;
        while (edges_pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic run_cells(input int n, input int mask_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 39) == 0) wait_edges_drained();
            send_random_cell(mask_pct);
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        i_s_tvalid = 1'b0;
        psel       = 1'b1;
        penable    = 1'b0;
        pwrite     = 1'b1;
        paddr      = {idx, 2'b00};
        pwdata     = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic reconfigure(input logic [2:0] which, input logic [12:0] w,
                               input logic [12:0] h, input logic [15:0] tgt);
        int unsigned w_fit;
        wait_edges_drained();
        w_fit = (w == '0) ? 1 : ((32'(w) > MAX_W) ? MAX_W : 32'(w));
        if ((which & SET_W) != 0 && w_fit > cur_w && !frame_start) begin
            // A wider row in mid-frame would read line store entries that were never
            // written, so the current frame is finished first.
            while (!frame_start) send_random_cell(50);
            wait_edges_drained();
        end
        if ((which & SET_W) != 0) begin
            apb_write(REG_GRID_WIDTH, 32'(w));
            cur_w = w_fit;
        end
        if ((which & SET_H) != 0) apb_write(REG_GRID_HEIGHT, 32'(h));
        if ((which & SET_TGT) != 0) begin
            apb_write(REG_MATCH_CLASS, 32'(tgt));
            cur_target = tgt;
        end
    endtask

    initial begin
        logic [2:0]  which;
        logic [12:0] w;
        logic [12:0] h;
        logic [15:0] tgt;
        int          n;
        int          roll;

        burst_left = int'($urandom_range(1, 40));
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Small 3x2 grid: every side of a mask cell, deferred bottom and right
        // edges, and a target-class cell whose value is not finite.
        reconfigure(SET_ALL, 13'd3, 13'd2, 16'h8000);
        send_cell(16'h8000, 1'b1);
        send_cell(16'h8000, 1'b1);
        send_cell(16'h8000, 1'b0);
        send_cell(16'h8000, 1'b1);
        send_cell(16'h7FFF, 1'b1);
        send_cell(16'h8000, 1'b1);

        // Zero sizes act as a 1x1 grid, so a lone mask cell has an edge on every side.
        reconfigure(SET_ALL, 13'd0, 13'd0, 16'h7FFF);
        send_cell(16'h7FFF, 1'b1);
        send_cell(16'h7FFF, 1'b0);
        send_cell(16'h0000, 1'b1);

        // Oversized sizes saturate to the largest grid, so the first cells of the
        // row and of the column see no border; shrinking the size then wraps.
        reconfigure(SET_ALL, 13'h1FFF, 13'h1FFF, 16'h0000);
        send_cell(cur_target, 1'b1);
        run_cells(18, 30);
        reconfigure(SET_W, 13'd1, 13'd0, 16'h0000);
        run_cells(12, 30);
        reconfigure(SET_H, 13'd0, 13'd0, 16'h0000);

        // Size changes in mid-frame: the counters past the new last index wrap.
        reconfigure(SET_W | SET_H, 13'd5, 13'd4, 16'h0000);
        run_cells(7, 60);
        reconfigure(SET_W, 13'd2, 13'd0, 16'h0000);
        run_cells(3, 60);
        reconfigure(SET_H, 13'd0, 13'd1, 16'h0000);
        run_cells(3, 60);

        while (random_sent < 420) begin
            which = 3'($urandom_range(1, 7));
            roll  = int'($urandom_range(0, 99));
            if (roll < 75)      w = 13'($urandom_range(1, 10));
            else if (roll < 92) w = 13'($urandom_range(11, 64));
            else                w = 13'd0;
            roll = int'($urandom_range(0, 99));
            if (roll < 80)      h = 13'($urandom_range(1, 8));
            else if (roll < 90) h = 13'd0;
            else                h = 13'($urandom_range(9, 20));
            roll = int'($urandom_range(0, 9));
            if (roll == 0)      tgt = 16'h8000;
            else if (roll == 1) tgt = 16'h7FFF;
            else                tgt = 16'($urandom);
            reconfigure(which, w, h, tgt);
            n = int'($urandom_range(8, 40));
            run_cells(n, int'($urandom_range(20, 85)));
            random_sent += n;
        end

        wait_edges_drained();
        if (fail_count == 0 && edges_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: raster_mask_boundary_edges_top.f
rtl/rmbe_pkg.sv
rtl/rmbe_cfg.sv
rtl/rmbe_line.sv
rtl/rmbe_emit.sv
rtl/raster_mask_boundary_edges_top.sv
tb/rmbe_edge_checker.sv
tb/testbench.sv
